// ----- hdl/i2cm_pkg.sv -----
// Shared types, step codes and the step-entry function of the I2C master byte engine.
`default_nettype none

package i2cm_pkg;

	// Command codes carried in the beat
	localparam logic [2:0] CMD_NONE  = 3'd0;
	localparam logic [2:0] CMD_START = 3'd1;
	localparam logic [2:0] CMD_STOP  = 3'd2;
	localparam logic [2:0] CMD_WRITE = 3'd3;
	localparam logic [2:0] CMD_READ  = 3'd4;

	// Configuration register indexes
	localparam logic [1:0] REG_BIT_DELAY   = 2'd0;
	localparam logic [1:0] REG_START_DELAY = 2'd1;
	localparam logic [1:0] REG_ACK_TIMEOUT = 2'd2;

	// Sequencer steps
	localparam logic [4:0] PH_IDLE = 5'd0;
	localparam logic [4:0] PH_S0   = 5'd1;
	localparam logic [4:0] PH_S1   = 5'd2;
	localparam logic [4:0] PH_S2   = 5'd3;
	localparam logic [4:0] PH_P0   = 5'd4;
	localparam logic [4:0] PH_P1   = 5'd5;
	localparam logic [4:0] PH_P2   = 5'd6;
	localparam logic [4:0] PH_W0   = 5'd7;
	localparam logic [4:0] PH_W1   = 5'd8;
	localparam logic [4:0] PH_W2   = 5'd9;
	localparam logic [4:0] PH_WA0  = 5'd10;
	localparam logic [4:0] PH_WA1  = 5'd11;
	localparam logic [4:0] PH_WA2  = 5'd12;
	localparam logic [4:0] PH_R0   = 5'd13;
	localparam logic [4:0] PH_R1   = 5'd14;
	localparam logic [4:0] PH_R2   = 5'd15;
	localparam logic [4:0] PH_A0   = 5'd16;
	localparam logic [4:0] PH_A1   = 5'd17;
	localparam logic [4:0] PH_A2   = 5'd18;
	localparam logic [4:0] PH_DONE = 5'd31;

	localparam logic [3:0] BITS_PER_BYTE = 4'd8;

	// Engine state
	typedef struct packed {
		logic [4:0] phase;
		logic [3:0] bit_count;
		logic [7:0] shift_byte;
		logic [7:0] delay_count;
		logic [7:0] wait_count;
		logic       scl;
		logic       sda;
		logic       sda_oe;
		logic       ack;
		logic       status;
		logic [7:0] rx_hold;
	} eng_state_t;

	// Configuration set
	typedef struct packed {
		logic [7:0] bit_delay;
		logic [7:0] start_delay;
		logic [7:0] ack_timeout;
	} eng_cfg_t;

	// A zero hold behaves as one tick
	function automatic logic [7:0] hold_of(input logic [7:0] d);
		return (d == 8'd0) ? 8'd1 : d;
	endfunction

	// Enter a step: apply its pin actions and load its hold
	function automatic eng_state_t enter_step(input eng_state_t s, input logic [4:0] p,
			input eng_cfg_t cfg);
		eng_state_t n;
		logic [7:0] d;
		n = s;
		d = hold_of(cfg.bit_delay);
		n.phase = p;
		case (p)
			PH_S0: begin
				n.sda_oe = 1'b1; n.scl = 1'b1; n.sda = 1'b1;
				d = hold_of(cfg.start_delay);
			end
			PH_S1: begin
				n.sda = 1'b0;
				d = hold_of(cfg.start_delay);
			end
			PH_S2: n.scl = 1'b0;
			PH_P0: begin
				n.sda_oe = 1'b1; n.scl = 1'b0; n.sda = 1'b0;
			end
			PH_P1: n.scl = 1'b1;
			PH_P2: n.sda = 1'b1;
			PH_W0: begin
				n.sda_oe = 1'b1; n.scl = 1'b0;
				n.sda = s.shift_byte[7];
				n.shift_byte = {s.shift_byte[6:0], 1'b0};
			end
			PH_W1: n.scl = 1'b1;
			PH_W2: n.scl = 1'b0;
			PH_WA0: begin
				n.sda_oe = 1'b0; n.sda = 1'b1;
			end
			PH_WA1: n.scl = 1'b1;
			PH_WA2: begin
				n.wait_count = cfg.ack_timeout;
				d = 8'd0;
			end
			PH_R0: begin
				n.sda_oe = 1'b0; n.scl = 1'b0;
			end
			PH_R1: n.scl = 1'b1;
			PH_R2: n.scl = 1'b0;
			PH_A0: begin
				n.scl = 1'b0; n.sda_oe = 1'b1; n.sda = ~s.ack;
			end
			PH_A1: n.scl = 1'b1;
			PH_A2: n.scl = 1'b0;
			default: begin
				n.phase = PH_IDLE;
				d = 8'd0;
			end
		endcase
		n.delay_count = d;
		return n;
	endfunction

endpackage

`default_nettype wire

// ----- hdl/i2c_master_byte_engine.sv -----
// Top level of the I2C master byte engine: beat handshake, configuration and state registers.
`default_nettype none

// Each input beat is one tick of the bus timing base; the engine takes one beat per clock
// cycle unless results stall and returns exactly one result beat for it, showing pin levels
// and status after that tick. The sequencer state register and a single output register
// set this: the next state is one pass of step logic, and the output register accepts a
// new beat in the same cycle its current beat is taken, so a beat can be accepted every
// cycle. Commands (start, stop, write byte, read byte) are taken only while idle and are
// otherwise ignored. Configuration writes are applied at once and should be made while idle.
module i2c_master_byte_engine
	import i2cm_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	// config port
	input  wire logic        cfg_wr_en,
	input  wire logic [1:0]  cfg_addr,
	input  wire logic [7:0]  cfg_wdata,
	// input stream
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	// [2:0] command, [10:3] tx_byte, [11] ack_enable, [12] sda_sample, [15:13] zero
	input  wire logic [15:0] s_axis_tdata,
	// result stream
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	// [0] scl_level, [1] sda_level, [2] sda_drive, [3] busy_res, [4] done_res,
	// [12:5] rx_byte, [13] status, [15:14] zero
	output logic [15:0]      m_axis_tdata
);

	eng_cfg_t   cfg_q;
	eng_state_t st_q;
	eng_state_t st_next;
	logic       step_done;
	logic       accept;
	logic [13:0] res_q;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.bit_delay   <= 8'd1;
			cfg_q.start_delay <= 8'd5;
			cfg_q.ack_timeout <= 8'd250;
		end else if (cfg_wr_en) begin
			unique case (cfg_addr)
				REG_BIT_DELAY:   cfg_q.bit_delay   <= cfg_wdata;
				REG_START_DELAY: cfg_q.start_delay <= cfg_wdata;
				REG_ACK_TIMEOUT: cfg_q.ack_timeout <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
	assign accept        = s_axis_tvalid && s_axis_tready;

	i2cm_step u_step (
		.cur        (st_q),
		.cfg        (cfg_q),
		.command    (s_axis_tdata[2:0]),
		.tx_byte    (s_axis_tdata[10:3]),
		.ack_enable (s_axis_tdata[11]),
		.sda_sample (s_axis_tdata[12]),
		.nxt        (st_next),
		.done       (step_done)
	);

	// Sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '{phase: PH_IDLE, bit_count: 4'd0, shift_byte: 8'd0, delay_count: 8'd0,
				wait_count: 8'd0, scl: 1'b1, sda: 1'b1, sda_oe: 1'b1, ack: 1'b0,
				status: 1'b0, rx_hold: 8'd0};
		end else if (accept) begin
			st_q <= st_next;
		end
	end

	// Result beat register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tvalid <= 1'b0;
		end else if (accept) begin
			m_axis_tvalid <= 1'b1;
		end else if (m_axis_tready) begin
			m_axis_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept)
			res_q <= {st_next.status, st_next.rx_hold, step_done,
				(st_next.phase != PH_IDLE), st_next.sda_oe, st_next.sda, st_next.scl};
	end

	assign m_axis_tdata = {2'b00, res_q};

endmodule

`default_nettype wire

// ----- hdl/i2cm_step.sv -----
// Next-state logic of the I2C master sequencer for one tick.
`default_nettype none

module i2cm_step
	import i2cm_pkg::*;
(
	input  wire eng_state_t cur,
	input  wire eng_cfg_t   cfg,
	input  wire logic [2:0] command,
	input  wire logic [7:0] tx_byte,
	input  wire logic       ack_enable,
	input  wire logic       sda_sample,
	output eng_state_t      nxt,
	output logic            done
);

	logic [7:0] dc;
	logic [3:0] bc;
	logic [4:0] nx;
	eng_state_t t;

	always_comb begin
		t    = cur;
		nxt  = cur;
		done = 1'b0;
		dc   = cur.delay_count;
		bc   = cur.bit_count;
		nx   = PH_DONE;
		if (cur.phase == PH_IDLE) begin
			// Idle: launch a command
			unique case (command)
				CMD_START: begin
					t.status = 1'b0;
					nxt = enter_step(t, PH_S0, cfg);
				end
				CMD_STOP: begin
					t.status = 1'b0;
					nxt = enter_step(t, PH_P0, cfg);
				end
				CMD_WRITE: begin
					t.status = 1'b0; t.bit_count = 4'd0; t.shift_byte = tx_byte;
					nxt = enter_step(t, PH_W0, cfg);
				end
				CMD_READ: begin
					t.status = 1'b0; t.bit_count = 4'd0; t.shift_byte = 8'd0;
					t.ack = ack_enable;
					nxt = enter_step(t, PH_R0, cfg);
				end
				default: nxt = cur;
			endcase
		end else if (cur.phase == PH_WA2) begin
			// Waiting for the slave acknowledge
			if (!sda_sample) begin
				nxt.scl   = 1'b0;
				nxt.phase = PH_IDLE;
				done      = 1'b1;
			end else if (cur.wait_count == 8'd0) begin
				t.status = 1'b1;
				nxt = enter_step(t, PH_P0, cfg);
			end else begin
				nxt.wait_count = cur.wait_count - 8'd1;
			end
		end else begin
			// Count down the hold, then move to the following step
			if (dc != 8'd0)
				dc = dc - 8'd1;
			t.delay_count = dc;
			nxt = t;
			if (dc == 8'd0) begin
				bc = cur.bit_count + 4'd1;
				unique case (cur.phase)
					PH_S0:  nx = PH_S1;
					PH_S1:  nx = PH_S2;
					PH_P0:  nx = PH_P1;
					PH_P1:  nx = PH_P2;
					PH_W0:  nx = PH_W1;
					PH_W1:  nx = PH_W2;
					PH_W2: begin
						t.bit_count = bc;
						nx = (bc < BITS_PER_BYTE) ? PH_W0 : PH_WA0;
					end
					PH_WA0: nx = PH_WA1;
					PH_WA1: nx = PH_WA2;
					PH_R0:  nx = PH_R1;
					PH_R1: begin
						t.bit_count = bc;
						nx = (bc < BITS_PER_BYTE) ? PH_R0 : PH_R2;
					end
					PH_R2:  nx = PH_A0;
					PH_A0:  nx = PH_A1;
					PH_A1:  nx = PH_A2;
					PH_A2: begin
						t.rx_hold = cur.shift_byte;
						nx = PH_DONE;
					end
					default: nx = PH_DONE;
				endcase
				if (nx == PH_DONE) begin
					nxt = t;
					nxt.phase = PH_IDLE;
					done = 1'b1;
				end else begin
					nxt = enter_step(t, nx, cfg);
					// Read data is sampled as SCL rises
					if (nx == PH_R1)
						nxt.shift_byte = {nxt.shift_byte[6:0], sda_sample};
				end
			end
		end
	end

endmodule

`default_nettype wire
